### sv/mdio_c22_pkg.sv
// shared types and constants of the clause 22 management master
package mdio_c22_pkg;

  localparam int PREAMBLE_BITS   = 32;
  localparam int ADDR_END_BITS   = 14;
  localparam int FRAME_TAIL_BITS = 32;

  // bit positions inside one frame
  localparam logic [6:0] DRIVE_END = 7'(PREAMBLE_BITS + ADDR_END_BITS);
  localparam logic [6:0] FRAME_END = 7'(PREAMBLE_BITS + FRAME_TAIL_BITS);
  localparam logic [6:0] PRE_LEN   = 7'(PREAMBLE_BITS);
  localparam logic [6:0] TA2_POS   = 7'd15;
  localparam logic [6:0] DATA_POS  = 7'd16;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;

  localparam logic [1:0] FRAME_START = 2'b01;
  localparam logic [1:0] OP_READ     = 2'b10;
  localparam logic [1:0] OP_WRITE    = 2'b01;
  localparam logic [1:0] TA_WRITE    = 2'b10;
  localparam logic [1:0] TA_READ     = 2'b00;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  phy_address;
    logic [4:0]  register_address;
    logic [15:0] write_value;
    logic        mdio_in;
  } cmd_t;

  typedef struct packed {
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic        turnaround_error;
  } res_t;

endpackage

### sv/mdio_clause22_master.sv
// clause 22 management master: frame sequencer driven by tick requests
//
// usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one request per cycle at most.
//   a tick request advances time by one tick; a read or write request starts
//   a frame when idle and is ignored while a frame is in progress.
//   res channel (res_valid / res_stall / res): exactly one result per request,
//   showing the line levels (mdc, mdio_out, mdio_drive), busy and done flags,
//   and the last read value with its turnaround error flag.
//   cfg_we / cfg_wdata write half_period (ticks per mdc half period).
// a result appears in the cycle after its request is accepted.
// throughput: one request per cycle unless a stalled result is waiting; the state
//   update and the output decode sit between the frame state registers and the result register.
// reset: synchronous rst returns the sequencer to idle, clears the read value
//   and error flag, empties the result register and loads half_period = 10.
// stall: while res_stall holds a waiting result, cmd_stall is raised and the
//   result stays unchanged; when the result leaves, a new request enters in
//   the same cycle.
module mdio_clause22_master (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  mdio_c22_pkg::cmd_t   cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mdio_c22_pkg::res_t   res,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  // configuration
  logic [15:0] half_period;

  // frame state
  logic        active;
  logic        reading;
  logic        clock_level;
  logic [15:0] half_counter;
  logic [6:0]  bit_position;
  logic [31:0] frame_shift;
  logic [15:0] capture_shift;
  logic        error_flag;
  logic [15:0] last_read;

  logic        active_next;
  logic        reading_next;
  logic        clock_level_next;
  logic [15:0] half_counter_next;
  logic [6:0]  bit_position_next;
  logic [31:0] frame_shift_next;
  logic [15:0] capture_shift_next;
  logic        error_flag_next;
  logic [15:0] last_read_next;
  logic        done;

  logic        accept;
  logic        load_res;
  logic [15:0] hp;
  logic [15:0] count_inc;
  logic [6:0]  bit_inc;
  logic [6:0]  k_cur;
  logic [6:0]  k_next;
  logic        start_rd;
  logic        drive_next;
  logic        level_next;
  mdio_c22_pkg::res_t res_next;

  // result register holds while stalled; input waits only then
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign load_res  = !cmd_stall;

  // zero half period behaves as one
  assign hp        = (half_period == 16'd0) ? 16'd1 : half_period;
  assign count_inc = half_counter + 16'd1;
  assign bit_inc   = bit_position + 7'd1;
  assign k_cur     = bit_position - mdio_c22_pkg::PRE_LEN;
  assign start_rd  = (cmd.kind == mdio_c22_pkg::KIND_READ);

  always_comb begin
    active_next        = active;
    reading_next       = reading;
    clock_level_next   = clock_level;
    half_counter_next  = half_counter;
    bit_position_next  = bit_position;
    frame_shift_next   = frame_shift;
    capture_shift_next = capture_shift;
    error_flag_next    = error_flag;
    last_read_next     = last_read;
    done               = 1'b0;

    if (!active && (cmd.kind == mdio_c22_pkg::KIND_READ ||
                    cmd.kind == mdio_c22_pkg::KIND_WRITE)) begin
      // new frame: begins in the low half of the first preamble bit
      active_next        = 1'b1;
      reading_next       = start_rd;
      clock_level_next   = 1'b0;
      half_counter_next  = 16'd0;
      bit_position_next  = 7'd0;
      capture_shift_next = 16'd0;
      frame_shift_next   = {mdio_c22_pkg::FRAME_START,
                            start_rd ? mdio_c22_pkg::OP_READ : mdio_c22_pkg::OP_WRITE,
                            cmd.phy_address, cmd.register_address,
                            start_rd ? mdio_c22_pkg::TA_READ : mdio_c22_pkg::TA_WRITE,
                            start_rd ? 16'd0 : cmd.write_value};
    end else if (active && cmd.kind == mdio_c22_pkg::KIND_TICK) begin
      half_counter_next = count_inc;
      if (count_inc >= hp) begin
        half_counter_next = 16'd0;
        if (!clock_level) begin
          // end of low half: sample turnaround and data on reads
          if (reading && bit_position >= mdio_c22_pkg::DRIVE_END) begin
            if (k_cur == mdio_c22_pkg::TA2_POS) begin
              error_flag_next = cmd.mdio_in;
            end else if (k_cur >= mdio_c22_pkg::DATA_POS) begin
              capture_shift_next = {capture_shift[14:0], cmd.mdio_in};
            end
          end
          clock_level_next = 1'b1;
        end else begin
          // end of high half: next bit or frame complete
          clock_level_next  = 1'b0;
          bit_position_next = bit_inc;
          if (bit_inc >= mdio_c22_pkg::FRAME_END) begin
            if (reading) begin
              last_read_next = capture_shift;
            end
            active_next       = 1'b0;
            reading_next      = 1'b0;
            bit_position_next = 7'd0;
            done              = 1'b1;
          end
        end
      end
    end
  end

  // line decode from the updated state
  assign k_next     = bit_position_next - mdio_c22_pkg::PRE_LEN;
  assign drive_next = active_next &&
                      (!reading_next || bit_position_next < mdio_c22_pkg::DRIVE_END);

  always_comb begin
    if (!drive_next || bit_position_next < mdio_c22_pkg::PRE_LEN) begin
      level_next = 1'b1;
    end else begin
      // msb first: frame bit k sits at position 31 - k
      level_next = frame_shift_next[~k_next[4:0]];
    end
  end

  always_comb begin
    res_next.mdc              = active_next && clock_level_next;
    res_next.mdio_out         = level_next;
    res_next.mdio_drive       = drive_next;
    res_next.busy_res         = active_next;
    res_next.done_res         = done;
    res_next.read_value       = last_read_next;
    res_next.turnaround_error = error_flag_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= mdio_c22_pkg::HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  // frame state, updated on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      reading       <= 1'b0;
      clock_level   <= 1'b0;
      half_counter  <= 16'd0;
      bit_position  <= 7'd0;
      frame_shift   <= 32'd0;
      capture_shift <= 16'd0;
      error_flag    <= 1'b0;
      last_read     <= 16'd0;
    end else if (accept) begin
      active        <= active_next;
      reading       <= reading_next;
      clock_level   <= clock_level_next;
      half_counter  <= half_counter_next;
      bit_position  <= bit_position_next;
      frame_shift   <= frame_shift_next;
      capture_shift <= capture_shift_next;
      error_flag    <= error_flag_next;
      last_read     <= last_read_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

### sv/mdio_c22_checker.sv
// port-level checks of the clause 22 management master, bound into every instance of it
module mdio_c22_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input logic                res_valid,
  input logic                res_stall,
  input mdio_c22_pkg::res_t  res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // every accepted request gives a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> res_valid)
    else $error("accepted request produced no result");

  // idle line: clock low and data released
  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.busy_res |-> !res.mdc && !res.mdio_drive && res.mdio_out)
    else $error("line active while idle");

  // completion ends the frame
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done while busy");

endmodule

bind mdio_clause22_master mdio_c22_checker u_mdio_c22_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 100ps
// testbench for the clause 22 management master, checked against a frame predictor
module tb_top;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;
  localparam int IDLE_PERCENT   = 24;
  localparam int NOISE_PERCENT  = 3;
  localparam int QUIET_FIRST    = 150;
  localparam int QUIET_LAST     = 450;
  localparam int RANDOM_ITEMS   = 200;
  localparam int MIN_FRAMES     = 2;
  localparam int SETTLE_CYCLES  = 3;
  localparam int SLOW_TICKS     = 40;
  // one frame is FRAME_END bits, each bit two mdc halves
  localparam int FRAME_HALVES   = 2 * int'(mdio_c22_pkg::FRAME_END);
  // two bits at the reset half period
  localparam int RESET_HP_TICKS = 4 * int'(mdio_c22_pkg::HALF_PERIOD_RESET);

  // the one encoding the kind field leaves unused
  localparam mdio_c22_pkg::kind_t KIND_UNUSED = mdio_c22_pkg::kind_t'(2'd3);

  // how the data line is modeled while a frame is being fed
  typedef enum logic [1:0] {
    LINE_RANDOM,
    LINE_HIGH,
    LINE_LOW
  } line_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  mdio_c22_pkg::cmd_t cmd = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  mdio_c22_pkg::res_t res;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;

  mdio_clause22_master dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // requests waiting to be driven, results waiting to arrive
  mdio_c22_pkg::cmd_t pending_q[$];
  mdio_c22_pkg::res_t result_q[$];

  int cycle_count    = 0;
  int quiet_run      = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int frames_seen    = 0;
  int fault_count    = 0;
  int reported       = 0;

  // no idling on either side inside this window
  wire quiet = (cycle_count >= QUIET_FIRST) && (cycle_count < QUIET_LAST);

  // predictor state, mirrors the sequencer registers
  logic [15:0] half_period_cfg = mdio_c22_pkg::HALF_PERIOD_RESET;
  logic        mdc_level       = 1'b0;
  logic [15:0] half_count      = '0;
  logic [6:0]  bit_pos         = '0;
  logic [31:0] frame_bits      = '0;
  logic [15:0] capture_bits    = '0;
  logic        frame_busy      = 1'b0;
  logic        frame_is_read   = 1'b0;
  logic        ta_error        = 1'b0;
  logic [15:0] read_word       = '0;

  // advance the frame predictor by one request and return the result it shows
  function automatic mdio_c22_pkg::res_t mdio_frame_step(mdio_c22_pkg::cmd_t c);
    mdio_c22_pkg::res_t r;
    logic        done;
    logic        drive;
    logic        level;
    int          hp;
    int          k;
    logic [1:0]  op;
    logic [1:0]  ta;
    logic [15:0] data;
    done = 1'b0;
    hp = (half_period_cfg == 16'd0) ? 1 : int'(half_period_cfg);
    if (!frame_busy && (c.kind == mdio_c22_pkg::KIND_READ ||
                        c.kind == mdio_c22_pkg::KIND_WRITE)) begin
      // a start takes no time: it opens the low half of the first preamble bit
      frame_busy = 1'b1;
      frame_is_read = (c.kind == mdio_c22_pkg::KIND_READ);
      mdc_level = 1'b0;
      half_count = '0;
      bit_pos = '0;
      capture_bits = '0;
      op = frame_is_read ? mdio_c22_pkg::OP_READ : mdio_c22_pkg::OP_WRITE;
      ta = frame_is_read ? mdio_c22_pkg::TA_READ : mdio_c22_pkg::TA_WRITE;
      data = frame_is_read ? 16'h0000 : c.write_value;
      frame_bits = {mdio_c22_pkg::FRAME_START, op, c.phy_address, c.register_address, ta,
                    data};
    end else if (frame_busy && c.kind == mdio_c22_pkg::KIND_TICK) begin
      half_count = half_count + 16'd1;
      if (int'(half_count) >= hp) begin
        half_count = '0;
        if (!mdc_level) begin
          // end of the low half: sample the released line on reads
          if (frame_is_read && bit_pos >= mdio_c22_pkg::DRIVE_END) begin
            k = int'(bit_pos) - int'(mdio_c22_pkg::PRE_LEN);
            if (k == int'(mdio_c22_pkg::TA2_POS)) ta_error = c.mdio_in;
            else if (k >= int'(mdio_c22_pkg::DATA_POS))
              capture_bits = {capture_bits[14:0], c.mdio_in};
          end
          mdc_level = 1'b1;
        end else begin
          mdc_level = 1'b0;
          bit_pos = bit_pos + 7'd1;
          if (bit_pos >= mdio_c22_pkg::FRAME_END) begin
            if (frame_is_read) read_word = capture_bits;
            frame_busy = 1'b0;
            frame_is_read = 1'b0;
            bit_pos = '0;
            done = 1'b1;
          end
        end
      end
    end
    // ticks while idle, starts while busy and the unused kind change nothing
    drive = frame_busy && (!frame_is_read || bit_pos < mdio_c22_pkg::DRIVE_END);
    k = int'(bit_pos) - int'(mdio_c22_pkg::PRE_LEN);
    if (!drive || bit_pos < mdio_c22_pkg::PRE_LEN || k > 31) level = 1'b1;
    else level = frame_bits[31 - k];
    r.mdc = frame_busy ? mdc_level : 1'b0;
    r.mdio_out = level;
    r.mdio_drive = drive;
    r.busy_res = frame_busy;
    r.done_res = done;
    r.read_value = read_word;
    r.turnaround_error = ta_error;
    return r;
  endfunction

  function automatic void queue_request(mdio_c22_pkg::kind_t k, logic [4:0] phy,
                                        logic [4:0] regad, logic [15:0] wv, logic line);
    mdio_c22_pkg::cmd_t c;
    c.kind = k;
    c.phy_address = phy;
    c.register_address = regad;
    c.write_value = wv;
    c.mdio_in = line;
    pending_q.push_back(c);
  endfunction

  // a start followed by enough ticks to finish the frame and a few idle ones;
  // returns how many of the queued requests the block acts on
  function automatic int queue_frame(mdio_c22_pkg::kind_t k, logic [4:0] phy,
                                     logic [4:0] regad, logic [15:0] wv, line_mode_t mode,
                                     int hp_eff, bit noisy);
    int   n;
    int   ticks;
    logic line;
    ticks = FRAME_HALVES * hp_eff;
    queue_request(k, phy, regad, wv, 1'($urandom_range(0, 1)));
    for (n = 0; n < ticks + 4; n++) begin
      // stray starts and unused kinds land only while the frame is surely busy
      if (noisy && n < ticks - 1 && $urandom_range(0, 99) < NOISE_PERCENT)
        queue_request(mdio_c22_pkg::kind_t'($urandom_range(1, 3)), 5'($urandom),
                      5'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      case (mode)
        LINE_HIGH: line = 1'b1;
        LINE_LOW:  line = 1'b0;
        default:   line = 1'($urandom_range(0, 1));
      endcase
      queue_request(mdio_c22_pkg::KIND_TICK, 5'($urandom), 5'($urandom), 16'($urandom),
                    line);
    end
    return 1 + ticks;
  endfunction

  // the register is only touched while nothing is in flight
  task automatic set_half_period(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 16'($urandom);
    half_period_cfg = v;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || cmd_valid || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver: holds the payload until it is taken
  always @(posedge clk) begin : driver
    logic fire;
    logic gap;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      fire = cmd_valid && !cmd_stall;
      gap = !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
      if (fire) begin
        result_q.push_back(mdio_frame_step(cmd));
        accepted_count++;
      end
      if (!cmd_valid || fire) begin
        if (!gap && pending_q.size() != 0) begin
          cmd <= pending_q.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin : monitor
    mdio_c22_pkg::res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          fault_count++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected result %0d with nothing predicted: %p", results_seen, res);
          end
        end else begin
          want = result_q.pop_front();
          if (res.done_res === 1'b1) frames_seen++;
          if (res !== want) begin
            fault_count++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("result %0d differs: expected mdc=%b out=%b drive=%b busy=%b done=%b",
                       results_seen, want.mdc, want.mdio_out, want.mdio_drive,
                       want.busy_res, want.done_res);
              $display("  read=%h ta_err=%b, got mdc=%b out=%b drive=%b busy=%b done=%b",
                       want.read_value, want.turnaround_error, res.mdc, res.mdio_out,
                       res.mdio_drive, res.busy_res, res.done_res);
              $display("  read=%h ta_err=%b", res.read_value, res.turnaround_error);
            end
          end
        end
      end
      res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // watchdog on cycles where neither channel moves anything
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet_run <= 0;
    else quiet_run <= quiet_run + 1;
    if (quiet_run >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                  random_effective;
    int                  frames_made;
    int                  n;
    int                  frame_count;
    int                  pick;
    int                  hp_eff;
    logic [15:0]         hp;
    mdio_c22_pkg::kind_t k;
    line_mode_t          mode;
    random_effective = 0;
    frames_made = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset half period: idle ticks, unused kind, the first two bits of a write with a stray read start
    queue_request(mdio_c22_pkg::KIND_TICK, 5'h1f, 5'h1f, 16'hffff, 1'b1);
    queue_request(KIND_UNUSED, 5'h00, 5'h00, 16'h0000, 1'b0);
    queue_request(mdio_c22_pkg::KIND_TICK, 5'h00, 5'h00, 16'h0000, 1'b0);
    queue_request(mdio_c22_pkg::KIND_WRITE, 5'h1f, 5'h00, 16'hffff, 1'b0);
    for (n = 0; n < RESET_HP_TICKS; n++) begin
      if (n == RESET_HP_TICKS / 2)
        queue_request(mdio_c22_pkg::KIND_READ, 5'h00, 5'h1f, 16'h0000, 1'b1);
      queue_request(mdio_c22_pkg::KIND_TICK, 5'($urandom), 5'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
    end
    drain();

    // the rest of that write at the fastest clock, then a few idle ticks
    set_half_period(16'd1);
    for (n = 0; n < FRAME_HALVES; n++)
      queue_request(mdio_c22_pkg::KIND_TICK, 5'($urandom), 5'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
    drain();

    // fastest clock: reads with the line stuck high and low
    void'(queue_frame(mdio_c22_pkg::KIND_READ, 5'h00, 5'h1f, 16'h0000, LINE_HIGH, 1, 1'b1));
    void'(queue_frame(mdio_c22_pkg::KIND_READ, 5'h15, 5'h0a, 16'hffff, LINE_LOW, 1, 1'b0));
    drain();

    // zero half period behaves like one, with an all-zero write
    set_half_period(16'd0);
    void'(queue_frame(mdio_c22_pkg::KIND_WRITE, 5'h00, 5'h00, 16'h0000, LINE_HIGH, 1, 1'b1));
    drain();

    // random phases, short half periods so frames stay cheap
    while (random_effective < RANDOM_ITEMS || frames_made < MIN_FRAMES) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       hp = 16'd0;
        6, 7:    hp = 16'd2;
        8, 9:    hp = 16'd3;
        default: hp = 16'd1;
      endcase
      hp_eff = (hp == 16'd0) ? 1 : int'(hp);
      set_half_period(hp);
      frame_count = $urandom_range(1, 2);
      for (n = 0; n < frame_count; n++) begin
        repeat ($urandom_range(0, 3))
          queue_request(mdio_c22_pkg::KIND_TICK, 5'($urandom), 5'($urandom), 16'($urandom),
                        1'($urandom_range(0, 1)));
        k = ($urandom_range(0, 1) != 0) ? mdio_c22_pkg::KIND_READ : mdio_c22_pkg::KIND_WRITE;
        pick = $urandom_range(0, 9);
        mode = (pick == 0) ? LINE_HIGH : (pick == 1) ? LINE_LOW : LINE_RANDOM;
        random_effective += queue_frame(k, 5'($urandom), 5'($urandom), 16'($urandom), mode,
                                        hp_eff, 1'b1);
        frames_made++;
      end
      drain();
    end

    // slowest clock: a read that stays in the low half of its first bit
    set_half_period(16'hffff);
    queue_request(mdio_c22_pkg::KIND_READ, 5'($urandom), 5'($urandom), 16'($urandom), 1'b0);
    for (n = 0; n < SLOW_TICKS; n++)
      queue_request(mdio_c22_pkg::KIND_TICK, 5'($urandom), 5'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)));
    drain();

    if (result_q.size() != 0) begin
      fault_count += result_q.size();
      $display("%0d predicted results never arrived", result_q.size());
    end
    $display("run covered %0d requests and %0d results, %0d frames completed",
             accepted_count, results_seen, frames_seen);
    $display("half periods 0 to 65535 with stray starts and unused kinds; %0d faults",
             fault_count);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
